### design/url_percent_escape_codec_defines.svh
// ----------------------------------------------------------------------------
// URL percent-escape codec assertion macros
// Shared concurrent assertion shorthands for the codec checker.
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_ESCAPE_CODEC_DEFINES_SVH
`define URL_PERCENT_ESCAPE_CODEC_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define UPEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upec assertion failed");

// Condition that must hold on every rising edge outside reset.
`define UPEC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("upec assertion failed");

`endif

### design/upec_pkg.sv
// ----------------------------------------------------------------------------
// URL percent-escape codec package
// Types, codes and character-class functions shared by the codec modules.
// ----------------------------------------------------------------------------
package upec_pkg;

  // Most bytes that one input byte can cause, and the width of a count of them.
  localparam int unsigned MaxResults = 7;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  localparam logic [7:0] PctChar    = 8'h25;
  localparam logic [3:0] NibbleMask = 4'hF;

  // Mode register codes.
  localparam logic [1:0] ModeNormalize = 2'd0;
  localparam logic [1:0] ModeEscape    = 2'd1;
  localparam logic [1:0] ModeUnescape  = 2'd2;
  localparam logic [1:0] ModeSpare     = 2'd3;

  // Lookahead hold codes.
  localparam logic [1:0] HeldNone  = 2'd0;
  localparam logic [1:0] HeldPct   = 2'd1;
  localparam logic [1:0] HeldDigit = 2'd2;
  localparam logic [1:0] HeldBad   = 2'd3;

  // Register map.
  localparam logic RegCodecMode = 1'b0;

  // The bytes one input byte produces, in order.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] data;
    logic [CntW-1:0]            cnt;
    logic                       last;
  } burst_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic is_reserved(input logic [7:0] c);
    logic r;
    case (c)
      8'h23, 8'h24, 8'h26, 8'h2B, 8'h2C, 8'h2F, 8'h3A,
      8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_unsafe(input logic [7:0] c);
    logic u;
    case (c)
      8'h22, 8'h23, 8'h25, 8'h3C, 8'h3E, 8'h40, 8'h5B, 8'h5C,
      8'h5D, 8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h3A: u = 1'b1;
      default: u = (c <= 8'h20) || (c >= 8'h7F);
    endcase
    return u;
  endfunction

  // Upper-case hex digit for a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  // Append one byte to a burst.
  function automatic burst_t push(input burst_t s, input logic [7:0] b);
    burst_t r;
    r = s;
    r.data[s.cnt] = b;
    r.cnt = s.cnt + CntW'(1);
    return r;
  endfunction

  // Append the three-byte escape of a byte.
  function automatic burst_t push_escaped(input burst_t s, input logic [7:0] b);
    burst_t r;
    r = push(s, PctChar);
    r = push(r, hex_char(b[7:4]));
    r = push(r, hex_char(b[3:0] & NibbleMask));
    return r;
  endfunction

  // Release held lookahead bytes as a broken escape.
  function automatic burst_t push_held(input burst_t s, input logic [1:0] m,
                                       input logic [1:0] hc, input logic [7:0] dig);
    burst_t r;
    r = s;
    if (hc == HeldPct || hc == HeldDigit) begin
      if (m == ModeNormalize) begin
        r = push_escaped(r, PctChar);
      end else begin
        r = push(r, PctChar);
      end
      if (hc == HeldDigit) begin
        r = push(r, dig);
      end
    end
    return r;
  endfunction

  // Handle a byte with nothing held; a '%' that is held produces nothing here.
  function automatic burst_t push_fresh(input burst_t s, input logic [1:0] m,
                                        input logic [7:0] b, input logic last);
    burst_t r;
    r = s;
    if (m == ModeEscape) begin
      if (is_reserved(b)) begin
        r = push_escaped(r, b);
      end else begin
        r = push(r, b);
      end
    end else if (b == PctChar) begin
      if (last) begin
        if (m == ModeNormalize) begin
          r = push_escaped(r, PctChar);
        end else begin
          r = push(r, PctChar);
        end
      end
    end else if (m == ModeNormalize && is_unsafe(b) && !is_reserved(b)) begin
      r = push_escaped(r, b);
    end else begin
      r = push(r, b);
    end
    return r;
  endfunction

endpackage

### design/upec_if.sv
// ----------------------------------------------------------------------------
// URL percent-escape codec stream interfaces
// Valid/ready channels for input and output characters.
// ----------------------------------------------------------------------------
interface upec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### design/upec_step.sv
// ----------------------------------------------------------------------------
// URL percent-escape codec step logic
// Holds the escape lookahead and builds the burst of bytes for one input.
// ----------------------------------------------------------------------------
module upec_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic [1:0]          mode_i,
  output upec_pkg::burst_t    burst_o
);

  logic [1:0] held_count_q, held_count_d;
  logic [7:0] held_digit_q, held_digit_d;

  // Decide the burst and the next lookahead state.
  always_comb begin
    upec_pkg::burst_t res;
    logic [1:0]       m;
    logic [1:0]       hc;
    logic             hex;
    res          = '0;
    m            = (mode_i == upec_pkg::ModeSpare) ? upec_pkg::ModeNormalize : mode_i;
    hc           = (held_count_q == upec_pkg::HeldBad) ? upec_pkg::HeldNone : held_count_q;
    hex          = upec_pkg::is_hex(in_byte_i);
    held_count_d = upec_pkg::HeldNone;
    held_digit_d = '0;

    if (m == upec_pkg::ModeEscape) begin
      res = upec_pkg::push_held(res, m, hc, held_digit_q);
      res = upec_pkg::push_fresh(res, m, in_byte_i, in_last_i);
    end else if (hc == upec_pkg::HeldPct && hex && !in_last_i) begin
      held_count_d = upec_pkg::HeldDigit;
      held_digit_d = in_byte_i;
    end else if (hc == upec_pkg::HeldDigit && hex) begin
      if (m == upec_pkg::ModeNormalize) begin
        res = upec_pkg::push(res, upec_pkg::PctChar);
        res = upec_pkg::push(res, held_digit_q);
        res = upec_pkg::push(res, in_byte_i);
      end else begin
        res = upec_pkg::push(res, {upec_pkg::hex_val(held_digit_q),
                                   upec_pkg::hex_val(in_byte_i)});
      end
    end else begin
      res = upec_pkg::push_held(res, m, hc, held_digit_q);
      res = upec_pkg::push_fresh(res, m, in_byte_i, in_last_i);
      if (in_byte_i == upec_pkg::PctChar && !in_last_i) begin
        held_count_d = upec_pkg::HeldPct;
      end
    end

    // The end of a string leaves nothing held.
    if (in_last_i) begin
      held_count_d = upec_pkg::HeldNone;
      held_digit_d = '0;
    end
    res.last = in_last_i;
    burst_o  = res;
  end

  // Lookahead state advances on every input transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= upec_pkg::HeldNone;
      held_digit_q <= '0;
    end else if (accept_i) begin
      held_count_q <= held_count_d;
      held_digit_q <= held_digit_d;
    end
  end

endmodule

### design/url_percent_escape_codec.sv
// ----------------------------------------------------------------------------
// URL percent-escape codec
// Normalizes, escapes or unescapes a byte stream under a mode register.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload             | Handshake
//  ---------+-----------+---------------------+-----------------------------
//  in_i     | sink      | in_byte, in_last    | valid/ready
//  out_o    | source    | out_byte, out_last  | valid/ready
//  APB      | slave     | codec_mode @ 0x0    | psel/penable, pready tied
//
// An input byte produces zero to seven output bytes; the output emits one
// byte per cycle while the sink does not hold ready low.
// The burst register and the output register both limit the rate: the next
// input is taken when the burst is empty or hands its final byte onward.
// Reset clears the mode to normalize and drops any held lookahead.
// ----------------------------------------------------------------------------
module url_percent_escape_codec (
  input  logic                clk_i,
  input  logic                rst_ni,
  upec_in_if.sink             in_i,
  upec_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [1:0]                   codec_mode_q;
  upec_pkg::burst_t             step_burst;
  upec_pkg::burst_t             burst_q;
  logic [upec_pkg::CntW-1:0]    rd_idx_q, rd_idx_d;
  logic                         out_valid_q, out_valid_d;
  logic [7:0]                   out_byte_q, out_byte_d;
  logic                         out_last_q, out_last_d;
  logic                         burst_valid, burst_one_left, out_free, move, in_accept;

  // Configuration register access.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == upec_pkg::RegCodecMode) ? {30'd0, codec_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_mode_q <= upec_pkg::ModeNormalize;
    end else if (psel && penable && pwrite && (paddr[2] == upec_pkg::RegCodecMode)) begin
      codec_mode_q <= pwdata[1:0];
    end
  end

  // Per-byte transform.
  upec_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_byte_i (in_i.in_byte),
    .in_last_i (in_i.in_last),
    .mode_i    (codec_mode_q),
    .burst_o   (step_burst)
  );

  // Handshake between the burst register and the output register.
  assign burst_valid    = rd_idx_q < burst_q.cnt;
  assign burst_one_left = (rd_idx_q + upec_pkg::CntW'(1)) == burst_q.cnt;
  assign out_free       = !out_valid_q || out_o.ready;
  assign move           = burst_valid && out_free;
  assign in_i.ready     = !burst_valid || (burst_one_left && out_free);
  assign in_accept      = in_i.valid && in_i.ready;

  // Next state of the read pointer and the output register.
  always_comb begin
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (out_free) begin
      out_valid_d = move;
    end
    if (move) begin
      out_byte_d = burst_q.data[rd_idx_q];
      out_last_d = burst_q.last && burst_one_left;
      rd_idx_d   = rd_idx_q + upec_pkg::CntW'(1);
    end
    if (in_accept) begin
      rd_idx_d = '0;
    end
  end

  // Control and burst registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      burst_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        burst_q <= step_burst;
      end
    end
  end

  // Output payload registers.
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;

endmodule

### design/upec_checker.sv
// ----------------------------------------------------------------------------
// URL percent-escape codec checker
// Port-level assertions on the output channel and the configuration port.
// ----------------------------------------------------------------------------
`include "url_percent_escape_codec_defines.svh"

module upec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_i,
  input logic        out_last_i,
  input logic        psel_i,
  input logic        penable_i,
  input logic        pwrite_i,
  input logic [2:0]  paddr_i,
  input logic [31:0] pwdata_i,
  input logic [31:0] prdata_i
);

  // A stalled output transaction keeps its bytes.
  `UPEC_ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, ##1 (out_valid_i && $stable(out_byte_i) && $stable(out_last_i)))

  // A mode write reads back on the next cycle.
  `UPEC_ASSERT_IMPL(a_mode_readback, clk_i, rst_ni, psel_i && penable_i && pwrite_i && (paddr_i[2] == 1'b0) ##1 (paddr_i[2] == 1'b0), prdata_i[1:0] == $past(pwdata_i[1:0]))

  // Only the two mode bits are ever read as set.
  `UPEC_ASSERT_ALWAYS(a_prdata_upper, clk_i, rst_ni, prdata_i[31:2] == 30'd0)

endmodule

bind url_percent_escape_codec upec_checker u_upec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.out_last),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

### test/tb_top.sv
// ----------------------------------------------------------------------------
// URL percent-escape codec testbench
// Drives byte strings into the codec under all four mode settings. The mode
// register is written over APB only while the codec is idle. Expected output
// bytes are predicted for every accepted input transaction and checked in
// order against the output channel. Both channels see random idle bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int          RandItems   = 460;
  localparam int          TailItems   = 40;
  localparam int          SettleCycles = 8;
  localparam int          TailCycles  = 24;
  localparam int          MaxReports  = 10;
  localparam longint      LimitNs     = 800_000;
  localparam logic [2:0]  ModeAddr    = {upec_pkg::RegCodecMode, 2'b00};

  localparam logic [12:0][7:0] ReservedSet = {
    8'h23, 8'h24, 8'h26, 8'h2B, 8'h2C, 8'h2F, 8'h3A,
    8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D
  };
  localparam logic [14:0][7:0] UnsafeSet = {
    8'h22, 8'h23, 8'h25, 8'h3C, 8'h3E, 8'h40, 8'h5B, 8'h5C,
    8'h5D, 8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h3A
  };

  // One entry of the stimulus list: an input byte or a mode register write.
  typedef struct {
    logic       is_cfg;
    logic [1:0] mode;
    logic [7:0] ch;
    logic       lst;
  } stim_t;

  typedef struct {
    logic [7:0] ch;
    logic       lst;
  } out_char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  upec_in_if  in_if ();
  upec_out_if out_if ();

  stim_t       stim_q[$];
  out_char_t   expected_chars_q[$];
  out_char_t   exp_c;

  // Shadow of the codec state and of its mode register.
  logic [1:0]  mode_model = upec_pkg::ModeNormalize;
  logic [1:0]  held_state = upec_pkg::HeldNone;
  logic [7:0]  held_char  = 8'h00;

  int          mismatch_cnt = 0;
  int          src_pct = 0;
  int          snk_pct = 0;
  logic [4:0]  src_gap;
  logic [4:0]  snk_gap;
  logic [7:0]  quiet_cnt;
  logic [5:0]  phase_cnt = '0;

  url_percent_escape_codec i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Character classes and expected-byte bookkeeping
  // --------------------------------------------------------------------------
  function automatic logic hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // Letters carry their value in the low nibble offset by nine.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    return c[6] ? c[3:0] + 4'd9 : c[3:0];
  endfunction

  function automatic logic reserved_char(input logic [7:0] c);
    logic r;
    r = 1'b0;
    for (int i = 0; i < 13; i++) begin
      if (c == ReservedSet[i]) r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic unsafe_char(input logic [7:0] c);
    logic u;
    u = (c <= 8'h20) || (c >= 8'h7F);
    for (int i = 0; i < 15; i++) begin
      if (c == UnsafeSet[i]) u = 1'b1;
    end
    return u;
  endfunction

  function automatic logic [7:0] upper_hex(input logic [3:0] n);
    return (n < 4'd10) ? 8'("0") + 8'(n) : 8'("A") + 8'(n) - 8'd10;
  endfunction

  function automatic void expect_char(input logic [7:0] c);
    expected_chars_q.push_back('{ch: c, lst: 1'b0});
  endfunction

  function automatic void expect_escape(input logic [7:0] c);
    expect_char(upec_pkg::PctChar);
    expect_char(upper_hex(c[7:4]));
    expect_char(upper_hex(c[3:0]));
  endfunction

  // Held lookahead released as a broken escape.
  function automatic void release_held(input logic [1:0] m);
    if (held_state == upec_pkg::HeldPct || held_state == upec_pkg::HeldDigit) begin
      if (m == upec_pkg::ModeNormalize) expect_escape(upec_pkg::PctChar);
      else expect_char(upec_pkg::PctChar);
      if (held_state == upec_pkg::HeldDigit) expect_char(held_char);
    end
    held_state = upec_pkg::HeldNone;
    held_char  = 8'h00;
  endfunction

  // A byte that arrives with nothing held.
  function automatic void expect_plain(input logic [1:0] m, input logic [7:0] b,
                                       input logic lst);
    if (m == upec_pkg::ModeEscape) begin
      if (reserved_char(b)) expect_escape(b);
      else expect_char(b);
    end else if (b == upec_pkg::PctChar) begin
      if (lst) begin
        if (m == upec_pkg::ModeNormalize) expect_escape(upec_pkg::PctChar);
        else expect_char(upec_pkg::PctChar);
      end else begin
        held_state = upec_pkg::HeldPct;
        held_char  = 8'h00;
      end
    end else if (m == upec_pkg::ModeNormalize && unsafe_char(b) && !reserved_char(b)) begin
      expect_escape(b);
    end else begin
      expect_char(b);
    end
  endfunction

  // Predict the output bytes caused by one accepted input byte.
  function automatic void predict_codec_bytes(input logic [7:0] b, input logic lst);
    logic [1:0] m;
    int         first;
    m     = (mode_model == upec_pkg::ModeSpare) ? upec_pkg::ModeNormalize : mode_model;
    first = expected_chars_q.size();
    if (m == upec_pkg::ModeEscape) begin
      release_held(m);
      expect_plain(m, b, lst);
    end else if (held_state == upec_pkg::HeldPct && hex_digit(b) && !lst) begin
      held_state = upec_pkg::HeldDigit;
      held_char  = b;
    end else if (held_state == upec_pkg::HeldDigit && hex_digit(b)) begin
      if (m == upec_pkg::ModeNormalize) begin
        expect_char(upec_pkg::PctChar);
        expect_char(held_char);
        expect_char(b);
      end else begin
        expect_char({hex_nibble(held_char), hex_nibble(b)});
      end
      held_state = upec_pkg::HeldNone;
      held_char  = 8'h00;
    end else begin
      release_held(m);
      expect_plain(m, b, lst);
    end
    if (lst) begin
      held_state = upec_pkg::HeldNone;
      held_char  = 8'h00;
      if (expected_chars_q.size() > first) begin
        expected_chars_q[expected_chars_q.size() - 1].lst = 1'b1;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus list helpers
  // --------------------------------------------------------------------------
  function automatic void add_item(input logic [7:0] c, input logic lst);
    stim_q.push_back('{is_cfg: 1'b0, mode: upec_pkg::ModeNormalize, ch: c, lst: lst});
  endfunction

  function automatic void add_mode(input logic [1:0] m);
    stim_q.push_back('{is_cfg: 1'b1, mode: m, ch: 8'h00, lst: 1'b0});
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'("0") + 8'(v);
    if (v < 16) return 8'("a") + 8'(v - 10);
    return 8'("A") + 8'(v - 16);
  endfunction

  function automatic int idle_chance();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_byte  = 8'h00;
    in_if.in_last  = 1'b0;
    out_if.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Idle burst likelihood is redrawn each time the phase counter wraps, including calm stretches.
  always @(posedge clk_i) begin
    phase_cnt <= phase_cnt + 6'd1;
    if (phase_cnt == '0) begin
      src_pct <= idle_chance();
      snk_pct <= idle_chance();
    end
  end

  // --------------------------------------------------------------------------
  // Driver: input transactions and mode register writes
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= 8'h00;
      in_if.in_last <= 1'b0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      src_gap       <= '0;
      quiet_cnt     <= '0;
    end else begin
      // Count cycles with no transaction on either channel.
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cnt <= '0;
      end else if (quiet_cnt != 8'hFF) begin
        quiet_cnt <= quiet_cnt + 8'd1;
      end
      if (in_if.valid && in_if.ready) predict_codec_bytes(in_if.in_byte, in_if.in_last);
      if (src_gap != '0) src_gap <= src_gap - 5'd1;

      if (psel && penable) begin
        // Access cycle: the register takes the value at this edge.
        if (pready) begin
          mode_model = pwdata[1:0];
          psel    <= 1'b0;
          penable <= 1'b0;
          pwrite  <= 1'b0;
        end
      end else if (psel) begin
        penable <= 1'b1;
      end else if (!in_if.valid || in_if.ready) begin
        if (stim_q.size() != 0 && stim_q[0].is_cfg) begin
          // A mode write waits until the codec has drained and settled.
          in_if.valid <= 1'b0;
          if (!in_if.valid && expected_chars_q.size() == 0 &&
              quiet_cnt >= SettleCycles) begin
            psel   <= 1'b1;
            pwrite <= 1'b1;
            paddr  <= ModeAddr;
            pwdata <= 32'(stim_q[0].mode);
            void'(stim_q.pop_front());
          end
        end else if (stim_q.size() != 0 && src_gap == '0 &&
                     (stim_q.size() < TailItems || $urandom_range(99) >= src_pct)) begin
          in_if.valid   <= 1'b1;
          in_if.in_byte <= stim_q[0].ch;
          in_if.in_last <= stim_q[0].lst;
          void'(stim_q.pop_front());
        end else begin
          // The idle burst starts with this cycle.
          in_if.valid <= 1'b0;
          if (stim_q.size() != 0 && src_gap == '0) src_gap <= 5'($urandom_range(0, 17));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: output backpressure and in-order comparison
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_gap      <= '0;
    end else begin
      if (snk_gap != '0) begin
        snk_gap      <= snk_gap - 5'd1;
        out_if.ready <= (snk_gap == 5'd1);
      end else if (stim_q.size() >= TailItems && $urandom_range(99) < snk_pct) begin
        snk_gap      <= 5'($urandom_range(1, 18));
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end

      if (out_if.valid && out_if.ready) begin
        if (expected_chars_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports) begin
            $display("[%0t] unexpected output byte %h last %b", $realtime,
                     out_if.out_byte, out_if.out_last);
          end
        end else begin
          exp_c = expected_chars_q.pop_front();
          if (out_if.out_byte !== exp_c.ch || out_if.out_last !== exp_c.lst) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports) begin
              $display("[%0t] output mismatch: expected byte %h last %b, got byte %h last %b",
                       $realtime, exp_c.ch, exp_c.lst, out_if.out_byte, out_if.out_last);
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int         n_rand;
    int         since;
    int         span;
    int         len;
    int         kind;
    logic       open_end;
    logic [7:0] str_q[$];

    // Normalize: zero byte, top byte, valid and broken escapes, reserved bytes.
    add_mode(upec_pkg::ModeNormalize);
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item("%", 1'b0);
    add_item("4", 1'b0);
    add_item("1", 1'b0);
    add_item("%", 1'b0);
    add_item("z", 1'b0);
    add_item("#", 1'b0);
    add_item("%", 1'b1);
    // Escape reserved bytes.
    add_mode(upec_pkg::ModeEscape);
    add_item("#", 1'b0);
    add_item("A", 1'b0);
    add_item(8'hFF, 1'b1);
    // Unescape, including a '%' and a hex digit cut off by the end of string.
    add_mode(upec_pkg::ModeUnescape);
    add_item("%", 1'b0);
    add_item("4", 1'b0);
    add_item("1", 1'b0);
    add_item("%", 1'b0);
    add_item("g", 1'b0);
    add_item("%", 1'b0);
    add_item("F", 1'b1);
    // Lookahead held across a switch into escape mode.
    add_mode(upec_pkg::ModeNormalize);
    add_item("%", 1'b0);
    add_item("a", 1'b0);
    add_mode(upec_pkg::ModeEscape);
    add_item("b", 1'b1);
    // The spare mode code acts as normalize.
    add_mode(upec_pkg::ModeSpare);
    add_item(" ", 1'b0);
    add_item("%", 1'b0);
    add_item("2", 1'b0);
    add_item("0", 1'b1);

    // Random strings, mostly built from escapes and special characters.
    n_rand = 0;
    since  = 0;
    span   = $urandom_range(30, 80);
    while (n_rand < RandItems) begin
      len = $urandom_range(1, 10);
      str_q.delete();
      while (str_q.size() < len) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          str_q.push_back(upec_pkg::PctChar);
          str_q.push_back(rand_hex());
          str_q.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : rand_hex());
        end else if (kind < 45) begin
          str_q.push_back(upec_pkg::PctChar);
        end else if (kind < 60) begin
          str_q.push_back(rand_hex());
        end else if (kind < 70) begin
          str_q.push_back(ReservedSet[$urandom_range(0, 12)]);
        end else if (kind < 80) begin
          str_q.push_back(UnsafeSet[$urandom_range(0, 14)]);
        end else if (kind < 90) begin
          str_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end else begin
          str_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      // Some strings run on into the next one without an end mark.
      open_end = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < str_q.size(); i++) begin
        add_item(str_q[i], (i == str_q.size() - 1) && !open_end);
        n_rand++;
        since++;
        // Mode switches land at random points, sometimes right after a '%'.
        if (since >= span || (str_q[i] == upec_pkg::PctChar && $urandom_range(0, 9) == 0)) begin
          add_mode(2'($urandom_range(0, 3)));
          since = 0;
          span  = $urandom_range(30, 80);
        end
      end
    end
    add_item("x", 1'b1);

    wait (rst_ni === 1'b1);
    while (stim_q.size() != 0 || in_if.valid || psel || expected_chars_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_chars_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #(LimitNs);
    $display("tb_top failed");
    $finish;
  end

endmodule
